@@ hw/rtl/scq_pkg.sv @@
// ----------------------------------------------------------------------------
// scq_pkg
// Shared types, constants and helpers of the servo command queue serializer.
// ----------------------------------------------------------------------------
package scq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int JOBQ_DEPTH  = 2;
    localparam int JOBQ_PTR_W  = $clog2(JOBQ_DEPTH);
    localparam int JOBQ_CNT_W  = $clog2(JOBQ_DEPTH + 1);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD   = 2'd0;
    localparam t_cmd CMD_SEND  = 2'd1;
    localparam t_cmd CMD_CLEAR = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_DONE  = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    localparam logic [11:0] PULSE_BASE = 12'd500;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  servo_channel;
        logic [10:0] position_q4;
        logic [15:0] move_time;
    } t_in_word;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        last;
        t_status     status;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  servo_channel;
        logic [10:0] position_q4;
        logic [15:0] move_time;
    } t_req;

    typedef struct packed {
        logic    is_send;
        t_status status;
        t_req    req;
    } t_job;

    function automatic logic [16:0] pow10(input logic [2:0] k);
        logic [16:0] v;
        unique case (k)
            3'd0:    v = 17'd1;
            3'd1:    v = 17'd10;
            3'd2:    v = 17'd100;
            3'd3:    v = 17'd1000;
            3'd4:    v = 17'd10000;
            default: v = 17'd1;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/scq_front.sv @@
// ----------------------------------------------------------------------------
// scq_front
// Accepts command words, keeps the request queue and issues jobs to the back.
// ----------------------------------------------------------------------------
module scq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  scq_pkg::t_in_word i_cmd_word,
    output logic             o_job_push,
    output scq_pkg::t_job    o_job,
    input  logic             i_job_full
);

    scq_pkg::t_req                  r_mem [scq_pkg::QUEUE_DEPTH];
    scq_pkg::t_req                  r_rd_data;
    logic [scq_pkg::PTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [scq_pkg::PTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [scq_pkg::CNT_W-1:0]      r_count, n_count;
    logic                           r_pend, n_pend;
    logic                           accept;
    logic                           q_full, q_empty;
    logic                           mem_wr, mem_rd;
    scq_pkg::t_req                  wr_req;
    scq_pkg::t_status               imm_status;
    logic                           imm_push;

    localparam logic [scq_pkg::CNT_W-1:0] DEPTH_CNT = scq_pkg::CNT_W'(scq_pkg::QUEUE_DEPTH);
    localparam logic [scq_pkg::PTR_W-1:0] LAST_PTR  = scq_pkg::PTR_W'(scq_pkg::QUEUE_DEPTH - 1);

    assign full    = r_pend | i_job_full;
    assign accept  = push & ~full;
    assign q_full  = (r_count == DEPTH_CNT);
    assign q_empty = (r_count == '0);
    assign wr_req  = '{servo_channel: i_cmd_word.servo_channel,
                       position_q4:   i_cmd_word.position_q4,
                       move_time:     i_cmd_word.move_time};

    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_count    = r_count;
        n_pend     = 1'b0;
        mem_wr     = 1'b0;
        mem_rd     = 1'b0;
        imm_push   = 1'b0;
        imm_status = scq_pkg::STATUS_DONE;
        if (accept) begin
            unique case (i_cmd_word.cmd)
                scq_pkg::CMD_ADD: begin
                    imm_push = 1'b1;
                    if (q_full) begin
                        imm_status = scq_pkg::STATUS_FULL;
                    end else begin
                        mem_wr   = 1'b1;
                        n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end
                scq_pkg::CMD_SEND: begin
                    if (q_empty) begin
                        imm_push   = 1'b1;
                        imm_status = scq_pkg::STATUS_EMPTY;
                    end else begin
                        mem_rd   = 1'b1;
                        n_pend   = 1'b1;
                        n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
                scq_pkg::CMD_CLEAR: begin
                    imm_push = 1'b1;
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                    n_count  = '0;
                end
                default: begin
                    imm_push = 1'b1;
                end
            endcase
        end
    end

    assign o_job_push = imm_push | r_pend;
    always_comb begin
        if (r_pend) begin
            o_job = '{is_send: 1'b1, status: scq_pkg::STATUS_DONE, req: r_rd_data};
        end else begin
            o_job = '{is_send: 1'b0, status: imm_status, req: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[r_wr_ptr] <= wr_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_pend   <= n_pend;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("request queue count above depth");

    a_send_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd_word.cmd == scq_pkg::CMD_SEND && !q_empty) |=> r_pend)
        else $error("send on non-empty queue did not start a read");

    a_pend_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (o_job_push && !i_job_full && o_job.is_send))
        else $error("pending send job not issued");
`endif

endmodule

@@ hw/rtl/scq_job_fifo.sv @@
// ----------------------------------------------------------------------------
// scq_job_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module scq_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  scq_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output scq_pkg::t_job o_job,
    output logic          o_empty
);

    scq_pkg::t_job                      r_slot [scq_pkg::JOBQ_DEPTH];
    logic [scq_pkg::JOBQ_PTR_W-1:0]     r_rd_ptr, r_wr_ptr;
    logic [scq_pkg::JOBQ_CNT_W-1:0]     r_count;
    logic                               do_push, do_pop;

    localparam logic [scq_pkg::JOBQ_CNT_W-1:0] DEPTH_CNT =
        scq_pkg::JOBQ_CNT_W'(scq_pkg::JOBQ_DEPTH);
    localparam logic [scq_pkg::JOBQ_PTR_W-1:0] LAST_PTR =
        scq_pkg::JOBQ_PTR_W'(scq_pkg::JOBQ_DEPTH - 1);

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/scq_back.sv @@
// ----------------------------------------------------------------------------
// scq_back
// Runs jobs one at a time: emits status words and serializes send lines byte by byte.
// ----------------------------------------------------------------------------
module scq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  scq_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  logic               pop,
    output logic               empty,
    output scq_pkg::t_out_word o_rsp_word
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHAN  = 11'b000_0000_0010,
        S_P     = 11'b000_0000_0100,
        S_PULSE = 11'b000_0000_1000,
        S_T     = 11'b000_0001_0000,
        S_TIME  = 11'b000_0010_0000,
        S_D     = 11'b000_0100_0000,
        S_ZERO  = 11'b000_1000_0000,
        S_CR    = 11'b001_0000_0000,
        S_LF    = 11'b010_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [16:0]         r_val, n_val;
    logic [2:0]          r_k, n_k;
    logic                r_started, n_started;
    logic [11:0]         r_pulse, n_pulse;
    logic [15:0]         r_time, n_time;
    logic                r_out_vld;
    scq_pkg::t_out_word  r_out;
    logic                adv, emit;
    scq_pkg::t_out_word  word;
    logic [16:0]         rem, step;
    logic [3:0]          dig;
    logic [13:0]         pos_x5;
    logic [11:0]         pulse_calc;

    function automatic scq_pkg::t_out_word char_word(input logic [7:0] c);
        scq_pkg::t_out_word w;
        w = '{byte_valid: 1'b1, out_byte: c, last: 1'b0, status: scq_pkg::STATUS_DONE};
        return w;
    endfunction

    assign adv        = ~r_out_vld | pop;
    assign empty      = ~r_out_vld;
    assign o_rsp_word = r_out;
    assign pos_x5     = {3'b000, i_job.req.position_q4} + {1'b0, i_job.req.position_q4, 2'b00};
    assign pulse_calc = scq_pkg::PULSE_BASE + pos_x5[13:2];

    // one decimal digit of r_val at weight 10^r_k, binary-weighted compare-subtract
    always_comb begin
        rem = r_val;
        dig = 4'd0;
        for (int b = 3; b >= 0; b--) begin
            step = scq_pkg::pow10(r_k) << b;
            if (rem >= step) begin
                rem    = rem - step;
                dig[b] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_k       = r_k;
        n_started = r_started;
        n_pulse   = r_pulse;
        n_time    = r_time;
        emit      = 1'b0;
        word      = '0;
        o_job_pop = 1'b0;
        if (adv) begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        o_job_pop = 1'b1;
                        emit      = 1'b1;
                        if (i_job.is_send) begin
                            word      = char_word(scq_pkg::CHAR_HASH);
                            n_state   = S_CHAN;
                            n_val     = {9'd0, i_job.req.servo_channel};
                            n_k       = 3'd2;
                            n_started = 1'b0;
                            n_pulse   = pulse_calc;
                            n_time    = i_job.req.move_time;
                        end else begin
                            word = '{byte_valid: 1'b0, out_byte: 8'd0, last: 1'b1,
                                     status: i_job.status};
                        end
                    end
                end
                S_CHAN, S_PULSE, S_TIME: begin
                    if (dig != 4'd0 || r_started || r_k == 3'd0) begin
                        emit      = 1'b1;
                        word      = char_word(scq_pkg::CHAR_0 + {4'd0, dig});
                        n_started = 1'b1;
                    end
                    n_val = rem;
                    n_k   = r_k - 1'b1;
                    if (r_k == 3'd0) begin
                        priority if (r_state == S_CHAN) begin
                            n_state = S_P;
                        end else if (r_state == S_PULSE) begin
                            n_state = S_T;
                        end else begin
                            n_state = S_D;
                        end
                    end
                end
                S_P: begin
                    emit      = 1'b1;
                    word      = char_word(scq_pkg::CHAR_P);
                    n_val     = {5'd0, r_pulse};
                    n_k       = 3'd3;
                    n_started = 1'b0;
                    n_state   = S_PULSE;
                end
                S_T: begin
                    emit      = 1'b1;
                    word      = char_word(scq_pkg::CHAR_T);
                    n_val     = {1'b0, r_time};
                    n_k       = 3'd4;
                    n_started = 1'b0;
                    n_state   = S_TIME;
                end
                S_D: begin
                    emit    = 1'b1;
                    word    = char_word(scq_pkg::CHAR_D);
                    n_state = S_ZERO;
                end
                S_ZERO: begin
                    emit    = 1'b1;
                    word    = char_word(scq_pkg::CHAR_0);
                    n_state = S_CR;
                end
                S_CR: begin
                    emit    = 1'b1;
                    word    = char_word(scq_pkg::CHAR_CR);
                    n_state = S_LF;
                end
                S_LF: begin
                    emit      = 1'b1;
                    word      = char_word(scq_pkg::CHAR_LF);
                    word.last = 1'b1;
                    n_state   = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_k       <= n_k;
        r_started <= n_started;
        r_pulse   <= n_pulse;
        r_time    <= n_time;
        if (adv) begin
            r_out <= word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_out_vld <= emit;
            end
        end
    end

`ifndef SYNTHESIS
    a_bytes_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.byte_valid) |-> (r_out.status == scq_pkg::STATUS_DONE))
        else $error("serial byte with non-done status");

    a_line_ends_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.byte_valid && r_out.last) |-> (r_out.out_byte == scq_pkg::CHAR_LF))
        else $error("line closed by a byte other than LF");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_state == S_IDLE && !i_job_empty))
        else $error("job taken while busy");
`endif

endmodule

@@ hw/rtl/servo_command_queue_serializer.sv @@
// ----------------------------------------------------------------------------
// servo_command_queue_serializer
// Servo request queue with an ASCII command line serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on i_cmd_word, taken when push is high and full low.
//   Add queues a request (16 deep), send pops the oldest and emits the line
//   '#'<chan>'P'<pulse>'T'<time>'D0' CR LF one byte per result word, clear
//   empties the queue. Result words leave on o_rsp_word while empty is low
//   and are taken when pop is high. Every command ends with a word with last.
//   A result word passes the job queue and the output register; a send
//   first reads the request storage. A send steps the serializer through
//   a state per character and per decimal digit place (3, 4 and 5 places),
//   the digit unit resolving one place a cycle unless the receiver stalls.
//   A two-entry job queue lets commands be accepted while a line is going
//   out; full rises when it fills, and for one cycle after a send while the
//   request storage read completes.
//   Reset empties the request queue, the job queue and the output register.
//   When the receiver stalls, the current word holds and the serializer
//   waits; the front keeps accepting until the job queue is full.
// ----------------------------------------------------------------------------
module servo_command_queue_serializer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  scq_pkg::t_in_word  i_cmd_word,
    output logic               empty,
    input  logic               pop,
    output scq_pkg::t_out_word o_rsp_word
);

    logic          job_push, job_full, job_pop, job_empty;
    scq_pkg::t_job job_in, job_out;

    scq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd_word (i_cmd_word),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    scq_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    scq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .pop         (pop),
        .empty       (empty),
        .o_rsp_word  (o_rsp_word)
    );

endmodule

@@ tb/sv/tb_servo_command_queue_serializer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_command_queue_serializer
// Self-checking bench for the servo command queue serializer. Command words
// are pushed through the input queue handshake and fed at acceptance into a
// behavioral model of the request queue and ASCII line formatter. Every
// popped result word is compared field by field against the oldest predicted
// word. Directed corner cases come first, then random traffic and queue
// overflow runs under several sender and receiver stall profiles.
// ----------------------------------------------------------------------------
module tb_servo_command_queue_serializer;

    localparam scq_pkg::t_cmd CMD_UNUSED   = 2'd3;
    localparam int            STALL_LIMIT  = 2000;
    localparam int            DRAIN_CYCLES = 40;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    scq_pkg::t_in_word  i_cmd_word;
    logic               empty;
    logic               pop;
    scq_pkg::t_out_word o_rsp_word;

    // model of the request queue
    scq_pkg::t_req req_store [scq_pkg::QUEUE_DEPTH];
    int unsigned   req_rd_ptr = 0;
    int unsigned   req_wr_ptr = 0;
    int unsigned   req_count  = 0;

    scq_pkg::t_out_word line_words [$];
    int unsigned        mismatch_count = 0;
    int unsigned        stall_cycles   = 0;
    int unsigned        send_idle_pct;
    int unsigned        recv_idle_pct;

    servo_command_queue_serializer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_cmd_word (i_cmd_word),
        .empty      (empty),
        .pop        (pop),
        .o_rsp_word (o_rsp_word)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic scq_pkg::t_out_word char_word(logic [7:0] c, logic is_last);
        scq_pkg::t_out_word w;
        w.byte_valid = 1'b1;
        w.out_byte   = c;
        w.last       = is_last;
        w.status     = scq_pkg::STATUS_DONE;
        return w;
    endfunction

    function automatic scq_pkg::t_out_word status_word(scq_pkg::t_status s);
        scq_pkg::t_out_word w;
        w.byte_valid = 1'b0;
        w.out_byte   = 8'h00;
        w.last       = 1'b1;
        w.status     = s;
        return w;
    endfunction

    function automatic void queue_decimal(int unsigned v);
        logic [7:0] digits [$];
        do begin
            digits.push_front(8'(scq_pkg::CHAR_0 + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i]) line_words.push_back(char_word(digits[i], 1'b0));
    endfunction

    function automatic void serialize_command(scq_pkg::t_in_word w);
        scq_pkg::t_req r;
        int unsigned   pulse;
        case (w.cmd)
            scq_pkg::CMD_ADD: begin
                if (req_count == scq_pkg::QUEUE_DEPTH) begin
                    line_words.push_back(status_word(scq_pkg::STATUS_FULL));
                end else begin
                    req_store[req_wr_ptr] = {w.servo_channel, w.position_q4, w.move_time};
                    req_wr_ptr = (req_wr_ptr + 1) % scq_pkg::QUEUE_DEPTH;
                    req_count++;
                    line_words.push_back(status_word(scq_pkg::STATUS_DONE));
                end
            end
            scq_pkg::CMD_SEND: begin
                if (req_count == 0) begin
                    line_words.push_back(status_word(scq_pkg::STATUS_EMPTY));
                end else begin
                    r = req_store[req_rd_ptr];
                    req_rd_ptr = (req_rd_ptr + 1) % scq_pkg::QUEUE_DEPTH;
                    req_count--;
                    pulse = scq_pkg::PULSE_BASE + ((int'(r.position_q4) * 5) >> 2);
                    line_words.push_back(char_word(scq_pkg::CHAR_HASH, 1'b0));
                    queue_decimal(r.servo_channel);
                    line_words.push_back(char_word(scq_pkg::CHAR_P, 1'b0));
                    queue_decimal(pulse);
                    line_words.push_back(char_word(scq_pkg::CHAR_T, 1'b0));
                    queue_decimal(r.move_time);
                    line_words.push_back(char_word(scq_pkg::CHAR_D, 1'b0));
                    line_words.push_back(char_word(scq_pkg::CHAR_0, 1'b0));
                    line_words.push_back(char_word(scq_pkg::CHAR_CR, 1'b0));
                    line_words.push_back(char_word(scq_pkg::CHAR_LF, 1'b1));
                end
            end
            scq_pkg::CMD_CLEAR: begin
                req_rd_ptr = 0;
                req_wr_ptr = 0;
                req_count  = 0;
                line_words.push_back(status_word(scq_pkg::STATUS_DONE));
            end
            default: begin
                line_words.push_back(status_word(scq_pkg::STATUS_DONE));
            end
        endcase
    endfunction

    function automatic scq_pkg::t_in_word cmd_word(scq_pkg::t_cmd c, logic [7:0] ch,
                                                   logic [10:0] pos, logic [15:0] mt);
        scq_pkg::t_in_word w;
        w.cmd           = c;
        w.servo_channel = ch;
        w.position_q4   = pos;
        w.move_time     = mt;
        return w;
    endfunction

    // bias toward each decimal digit count
    function automatic int unsigned rand_decimal(int unsigned maxv);
        int unsigned v;
        case ($urandom_range(3))
            0:       v = $urandom_range(9);
            1:       v = $urandom_range(99);
            2:       v = $urandom_range(999);
            default: v = $urandom_range(maxv);
        endcase
        return (v > maxv) ? maxv : v;
    endfunction

    function automatic scq_pkg::t_in_word random_command(scq_pkg::t_cmd c);
        logic [10:0] pos;
        pos = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                       : 11'($urandom_range(1600));
        return cmd_word(c, 8'(rand_decimal(255)), pos, 16'(rand_decimal(65535)));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic send_command(input scq_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_cmd_word <= w;
        do @(posedge i_clk); while (full);
        serialize_command(w);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (line_words.size() != 0);
    endtask

    // result check and receiver stalls
    always @(posedge i_clk) begin : rsp_check
        scq_pkg::t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (line_words.size() == 0) begin
                report_mismatch("unexpected word", o_rsp_word, 0);
            end else begin
                want = line_words.pop_front();
                if (o_rsp_word.byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", o_rsp_word.byte_valid, want.byte_valid);
                if (o_rsp_word.out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_rsp_word.out_byte, want.out_byte);
                if (o_rsp_word.last !== want.last)
                    report_mismatch("last", o_rsp_word.last, want.last);
                if (o_rsp_word.status !== want.status)
                    report_mismatch("status", o_rsp_word.status, want.status);
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic test_basic_commands();
        send_command(cmd_word(scq_pkg::CMD_SEND, 8'd0, 11'd0, 16'd0));
        send_command(cmd_word(CMD_UNUSED, 8'd0, 11'd0, 16'd0));
        send_command(cmd_word(scq_pkg::CMD_CLEAR, 8'd0, 11'd0, 16'd0));
        send_command(cmd_word(scq_pkg::CMD_ADD, 8'd0, 11'd0, 16'd0));
        send_command(cmd_word(scq_pkg::CMD_ADD, 8'd255, 11'd2047, 16'd65535));
        send_command(cmd_word(scq_pkg::CMD_ADD, 8'd9, 11'd1600, 16'd9));
        send_command(cmd_word(scq_pkg::CMD_ADD, 8'd10, 11'd1, 16'd10));
        send_command(cmd_word(scq_pkg::CMD_ADD, 8'd99, 11'd4, 16'd1000));
        repeat (5) send_command(cmd_word(scq_pkg::CMD_SEND, 8'd0, 11'd0, 16'd0));
        send_command(cmd_word(scq_pkg::CMD_SEND, 8'd255, 11'd2047, 16'd65535));
        send_command(cmd_word(CMD_UNUSED, 8'd255, 11'd2047, 16'd65535));
        send_command(cmd_word(scq_pkg::CMD_ADD, 8'd100, 11'd1599, 16'd10000));
        send_command(cmd_word(scq_pkg::CMD_CLEAR, 8'd255, 11'd2047, 16'd65535));
        send_command(cmd_word(scq_pkg::CMD_SEND, 8'd0, 11'd0, 16'd0));
        send_command(cmd_word(scq_pkg::CMD_ADD, 8'd100, 11'd1599, 16'd10000));
        send_command(cmd_word(scq_pkg::CMD_SEND, 8'd0, 11'd0, 16'd0));
        wait_drained();
    endtask

    task automatic test_queue_overflow();
        send_command(random_command(scq_pkg::CMD_CLEAR));
        repeat (scq_pkg::QUEUE_DEPTH + 2) send_command(random_command(scq_pkg::CMD_ADD));
        repeat (scq_pkg::QUEUE_DEPTH + 1) send_command(random_command(scq_pkg::CMD_SEND));
    endtask

    task automatic test_random_traffic(input int n);
        int            burst;
        int            pick;
        scq_pkg::t_cmd c;
        while (n > 0) begin
            if ($urandom_range(99) < 60) begin
                burst = $urandom_range(1, 8);
                repeat (burst) send_command(random_command(scq_pkg::CMD_ADD));
                repeat (burst) send_command(random_command(scq_pkg::CMD_SEND));
                n -= 2 * burst;
            end else begin
                pick = $urandom_range(19);
                if (pick == 0)
                    c = scq_pkg::CMD_CLEAR;
                else if (pick == 1)
                    c = CMD_UNUSED;
                else if (pick < 11)
                    c = scq_pkg::CMD_ADD;
                else
                    c = scq_pkg::CMD_SEND;
                send_command(random_command(c));
                if (c != CMD_UNUSED)
                    n--;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        i_cmd_word    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_commands();

        send_idle_pct = 7;
        recv_idle_pct = 84;
        test_random_traffic(110);
        test_queue_overflow();

        send_idle_pct = 84;
        recv_idle_pct = 7;
        test_random_traffic(110);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_queue_overflow();
        test_random_traffic(110);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
